>>> hdl/pftr_pkg.sv
`timescale 1ns / 1ps
// Package for the page framebuffer text renderer: geometry constants,
// command codes, state type and the 5x7 font table. No dependencies.
package pftr_pkg;

  localparam int Width     = 128;
  localparam int Pages     = 8;
  localparam int ColW      = $clog2(Width);
  localparam int PageW     = (Pages > 1) ? $clog2(Pages) : 1;
  localparam int Depth     = Width * Pages;
  localparam int AddrW     = $clog2(Depth);
  localparam int FirstCode = 32;
  localparam int LastCode  = 126;

  typedef enum logic [2:0] {
    CMD_CHAR  = 3'd0,
    CMD_DIGIT = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_DIGIT,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_RESP
  } state_t;

  // Glyph column for a code; codes outside the printable range draw as space.
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] i);
    logic [39:0] g;
    begin
      g = 40'h0;
      case (code)
        8'd33: g = 40'h00005F0000; 8'd34: g = 40'h0007000700; 8'd35: g = 40'h147F147F14;
        8'd36: g = 40'h242A7F2A12; 8'd37: g = 40'h2313086462; 8'd38: g = 40'h3649552250;
        8'd39: g = 40'h0005030000; 8'd40: g = 40'h001C224100; 8'd41: g = 40'h0041221C00;
        8'd42: g = 40'h14083E0814; 8'd43: g = 40'h08083E0808; 8'd44: g = 40'h0050300000;
        8'd45: g = 40'h0808080808; 8'd46: g = 40'h0060600000; 8'd47: g = 40'h2010080402;
        8'd48: g = 40'h3E5149453E; 8'd49: g = 40'h00427F4000; 8'd50: g = 40'h4261514946;
        8'd51: g = 40'h2141454B31; 8'd52: g = 40'h1814127F10; 8'd53: g = 40'h2745454539;
        8'd54: g = 40'h3C4A494930; 8'd55: g = 40'h0171090503; 8'd56: g = 40'h3649494936;
        8'd57: g = 40'h064949291E; 8'd58: g = 40'h0036360000; 8'd59: g = 40'h0056360000;
        8'd60: g = 40'h0814224100; 8'd61: g = 40'h1414141414; 8'd62: g = 40'h0041221408;
        8'd63: g = 40'h0201510906; 8'd64: g = 40'h324979413E; 8'd65: g = 40'h7E1111117E;
        8'd66: g = 40'h7F49494936; 8'd67: g = 40'h3E41414122; 8'd68: g = 40'h7F4141221C;
        8'd69: g = 40'h7F49494941; 8'd70: g = 40'h7F09090901; 8'd71: g = 40'h3E4149497A;
        8'd72: g = 40'h7F0808087F; 8'd73: g = 40'h00417F4100; 8'd74: g = 40'h2040413F01;
        8'd75: g = 40'h7F08142241; 8'd76: g = 40'h7F40404040; 8'd77: g = 40'h7F020C027F;
        8'd78: g = 40'h7F0408107F; 8'd79: g = 40'h3E4141413E; 8'd80: g = 40'h7F09090906;
        8'd81: g = 40'h3E4151215E; 8'd82: g = 40'h7F09192946; 8'd83: g = 40'h4649494931;
        8'd84: g = 40'h01017F0101; 8'd85: g = 40'h3F4040403F; 8'd86: g = 40'h1F2040201F;
        8'd87: g = 40'h3F4038403F; 8'd88: g = 40'h6314081463; 8'd89: g = 40'h0708700807;
        8'd90: g = 40'h6151494543; 8'd91: g = 40'h007F414100; 8'd92: g = 40'h0204081020;
        8'd93: g = 40'h0041417F00; 8'd94: g = 40'h0402010204; 8'd95: g = 40'h4040404040;
        8'd96: g = 40'h0001020400; 8'd97: g = 40'h2054545478; 8'd98: g = 40'h7F48444438;
        8'd99: g = 40'h3844444420; 8'd100: g = 40'h384444487F; 8'd101: g = 40'h3854545418;
        8'd102: g = 40'h087E090102; 8'd103: g = 40'h0C5252523E; 8'd104: g = 40'h7F08040478;
        8'd105: g = 40'h00447D4000; 8'd106: g = 40'h2040443D00; 8'd107: g = 40'h7F10284400;
        8'd108: g = 40'h00417F4000; 8'd109: g = 40'h7C04180478; 8'd110: g = 40'h7C08040478;
        8'd111: g = 40'h3844444438; 8'd112: g = 40'h7C14141408; 8'd113: g = 40'h081414187C;
        8'd114: g = 40'h7C08040408; 8'd115: g = 40'h4854545420; 8'd116: g = 40'h043F444020;
        8'd117: g = 40'h3C4040207C; 8'd118: g = 40'h1C2040201C; 8'd119: g = 40'h3C4030403C;
        8'd120: g = 40'h4428102844; 8'd121: g = 40'h0C5050503C; 8'd122: g = 40'h4464544C44;
        8'd123: g = 40'h0008364100; 8'd124: g = 40'h00007F0000; 8'd125: g = 40'h0041360800;
        8'd126: g = 40'h0804081008;
        default: g = 40'h0;
      endcase
      case (i)
        3'd0: glyph_col = g[39:32];
        3'd1: glyph_col = g[31:24];
        3'd2: glyph_col = g[23:16];
        3'd3: glyph_col = g[15:8];
        3'd4: glyph_col = g[7:0];
        default: glyph_col = 8'h00;
      endcase
    end
  endfunction

  // Spread the glyph bits of page band p into pixel triples, low 8 bits kept.
  function automatic logic [7:0] spread3(input logic [7:0] g, input logic [1:0] p);
    logic [8:0] acc;
    logic [2:0] b;
    begin
      case (p)
        2'd0: b = g[2:0];
        2'd1: b = g[5:3];
        2'd2: b = {1'b0, g[7:6]};
        default: b = 3'b000;
      endcase
      acc = {{3{b[2]}}, {3{b[1]}}, {3{b[0]}}};
      spread3 = acc[7:0];
    end
  endfunction

endpackage

>>> hdl/pftr_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module pftr_ram #(
  parameter int DataW = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [DataW-1:0]         wdata,
  output logic [DataW-1:0]         rdata
);
  logic [DataW-1:0] mem [Depth];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hdl/page_framebuffer_text_renderer.sv
`timescale 1ns / 1ps
// Top level of the page framebuffer text renderer: command sequencer over the
// frame store RAM. Depends on pftr_pkg and pftr_ram.
//
//  channel | direction | ports                  | payload
//  in      | sink      | in_tvalid/in_tready    | in_tdata: cmd, column, page_row, symbol
//  out     | source    | out_tvalid/out_tready  | out_tdata: read_data
//  cfg     | write     | cfg_we/cfg_wdata       | display_enabled
//
// An item is taken only in ST_IDLE. Char, large digit, fill and clear then step
// through their RAM writes, one per cycle, and a read waits in ST_RESP until the
// receiver is ready, so no new item is taken before the last one is through.
// After reset a clearing pass over the whole frame store runs before the first
// item is taken. A pending result holds the next item back until it is taken.
module page_framebuffer_text_renderer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd[2:0], column[10:3], page_row[18:11], symbol[26:19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_data[7:0]
  input  logic        cfg_we,
  input  logic        cfg_wdata   // display_enabled
);
  import pftr_pkg::*;

  state_t state_r, state_nxt;
  logic   en_r;
  logic [2:0] cmd_r;
  logic [7:0] col_r, page_r, sym_r;
  logic [AddrW:0] cnt_r, cnt_nxt;   // char/fill/clear step
  logic [1:0] p_r, p_nxt;           // digit page band
  logic [2:0] i_r, i_nxt;           // digit glyph column
  logic [1:0] s_r, s_nxt;           // digit repeat
  logic       ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;
  logic [8:0] wcol;
  logic [8:0] wpage;
  logic       in_rng, rd_ok_r;
  logic       done;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else if (cfg_we) begin
      en_r <= cfg_wdata;
    end
  end

  // Read data stays on the RAM output while the response waits
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_RESP);
  assign out_tdata  = rd_ok_r ? ram_rdata : 8'h00;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[2:0] == CMD_READ) state_nxt = ST_READ;
          else if (!en_r) state_nxt = ST_IDLE;
          else begin
            case (in_tdata[2:0])
              CMD_CHAR:  state_nxt = ST_CHAR;
              CMD_DIGIT: state_nxt = (in_tdata[26:19] >= 8'd48 && in_tdata[26:19] <= 8'd57)
                                     ? ST_DIGIT : ST_IDLE;
              CMD_FILL:  state_nxt = ST_FILL;
              CMD_CLEAR: state_nxt = ST_CLEAR;
              default:   state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_CHAR, ST_DIGIT, ST_FILL, ST_CLEAR: if (done) state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Step counters and last-step detect
  always_comb begin
    cnt_nxt = cnt_r + 1'b1;
    p_nxt = p_r; i_nxt = i_r; s_nxt = s_r;
    done = 1'b0;
    case (state_r)
      ST_CHAR:  done = (cnt_r == (AddrW+1)'(5));
      ST_FILL:  done = (cnt_r == (AddrW+1)'(Width - 1));
      ST_CLEAR: done = (cnt_r == (AddrW+1)'(Depth - 1));
      ST_DIGIT: begin
        if (s_r != 2'd2) s_nxt = s_r + 2'd1;
        else begin
          s_nxt = 2'd0;
          if (i_r != 3'd4) i_nxt = i_r + 3'd1;
          else begin
            i_nxt = 3'd0;
            p_nxt = p_r + 2'd1;
          end
        end
        done = (s_r == 2'd2) && (i_r == 3'd4) && (p_r == 2'd2);
      end
      default: cnt_nxt = '0;
    endcase
    if (state_r == ST_IDLE) begin
      p_nxt = 2'd0; i_nxt = 3'd0; s_nxt = 2'd0;
    end
  end

  // RAM address, data and write enable
  always_comb begin
    wcol  = {1'b0, col_r};
    wpage = {1'b0, page_r};
    ram_wdata = 8'h00;
    case (state_r)
      ST_CHAR: begin
        wcol = {1'b0, col_r} + 9'(cnt_r[2:0]);
        ram_wdata = (cnt_r[2:0] == 3'd5) ? 8'h00 :
          glyph_col((sym_r < 8'(FirstCode) || sym_r > 8'(LastCode)) ? 8'(FirstCode) : sym_r,
                    cnt_r[2:0]);
      end
      ST_DIGIT: begin
        wcol  = {1'b0, col_r} + 9'({i_r, 1'b0}) + 9'(i_r) + 9'(s_r);
        wpage = {1'b0, page_r} + 9'(p_r);
        ram_wdata = spread3(glyph_col(sym_r, i_r), p_r);
      end
      ST_FILL: begin
        wcol = 9'(cnt_r[ColW-1:0]);
        ram_wdata = sym_r;
      end
      default: ;
    endcase
    in_rng = (wcol < 9'(Width)) && (wpage < 9'(Pages));
    if (state_r == ST_CLEAR) ram_addr = cnt_r[AddrW-1:0];
    else ram_addr = AddrW'(wpage[PageW-1:0]) * AddrW'(Width) + AddrW'(wcol[ColW-1:0]);
    ram_we = ((state_r == ST_CHAR) || (state_r == ST_DIGIT) || (state_r == ST_FILL))
             ? in_rng : (state_r == ST_CLEAR);
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      p_r <= 2'd0; i_r <= 3'd0; s_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt == state_r && !done) ? cnt_nxt : '0;
      p_r <= p_nxt; i_r <= i_nxt; s_r <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tdata[2:0];
      col_r  <= in_tdata[10:3];
      page_r <= in_tdata[18:11];
      sym_r  <= in_tdata[26:19];
    end
    if (state_r == ST_READ) begin
      rd_ok_r <= en_r && in_rng;
    end
  end

  pftr_ram #(.DataW(8), .Depth(Depth)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

`ifndef SYNTH
  a_no_write_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_RESP) |-> !ram_we)
    else $error("write during read");
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("response dropped");
  a_read_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (cmd_r == CMD_READ))
    else $error("read state without read item");
`endif
endmodule

>>> tb/tb_page_framebuffer_text_renderer.sv
`timescale 1ns / 1ps
// Testbench for the page framebuffer text renderer: drives draw, fill, clear
// and read commands, predicts every read byte with a frame store model and
// compares. Depends on pftr_pkg and the renderer RTL.
module tb_page_framebuffer_text_renderer;
  import pftr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // cmd[2:0], column[10:3], page_row[18:11], symbol[26:19]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // read_data[7:0]
  logic        cfg_we;
  logic        cfg_wdata;

  page_framebuffer_text_renderer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Font: column i of glyph for codes 32..126, packed five bytes per code.
  localparam logic [39:0] FontRom [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
  };

  logic [7:0] model_store [0:Depth-1];
  logic       model_enabled;
  logic [7:0] read_queue [$];
  int         error_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         recv_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] font_col(input logic [7:0] code, input int i);
    logic [39:0] g;
    if (code < FirstCode || code > LastCode) code = FirstCode;
    g = FontRom[code - FirstCode];
    return g[39 - 8*i -: 8];
  endfunction

  function automatic void store_byte(input int col, input int page, input logic [7:0] v);
    if (col < Width && page < Pages) model_store[page*Width + col] = v;
  endfunction

  // Apply one command to the frame store model; queue the byte a read returns.
  function automatic void render_predict(input logic [2:0] cmd, input logic [7:0] col,
                                         input logic [7:0] page, input logic [7:0] sym);
    logic [7:0] g;
    logic [7:0] acc;
    if (cmd == CMD_READ) begin
      if (model_enabled && col < Width && page < Pages)
        read_queue.push_back(model_store[page*Width + col]);
      else
        read_queue.push_back(8'h00);
      return;
    end
    if (!model_enabled) return;
    case (cmd)
      CMD_CHAR: begin
        for (int i = 0; i < 5; i++) store_byte(col + i, page, font_col(sym, i));
        store_byte(col + 5, page, 8'h00);
      end
      CMD_DIGIT: begin
        if (sym >= "0" && sym <= "9") begin
          for (int p = 0; p < 3; p++)
            for (int i = 0; i < 5; i++) begin
              g = font_col(sym, i);
              acc = 8'h00;
              for (int r = 0; r < 8; r++)
                if (g[r] && r / 3 == p) acc = acc | 8'(9'h7 << (3 * (r % 3)));
              for (int s = 0; s < 3; s++) store_byte(col + 3*i + s, page + p, acc);
            end
        end
      end
      CMD_FILL: for (int i = 0; i < Width; i++) store_byte(i, page, sym);
      CMD_CLEAR: for (int a = 0; a < Depth; a++) model_store[a] = 8'h00;
      default: ;
    endcase
  endfunction

  // Offer one item until accepted, then update the prediction.
  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] col,
                          input logic [7:0] page, input logic [7:0] sym);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, sym, page, col, cmd};
    do @(posedge clk); while (!in_tready);
    render_predict(cmd, col, page, sym);
  endtask

  // Drain outstanding reads, let the sequencer settle, then write the register.
  task automatic set_enabled(input logic en);
    in_tvalid <= 1'b0;
    while (read_queue.size() != 0) @(posedge clk);
    repeat (Depth + 20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_enabled = en;
  endtask

  // Receiver: random stalls, plus a hold the pressure test controls.
  always @(posedge clk) begin
    out_tready <= !recv_hold &&
                  !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // Check every accepted read byte against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (read_queue.size() == 0) begin
        $error("read_data: unexpected item, actual %0h", out_tdata);
        error_count++;
      end else begin
        if (out_tdata !== read_queue[0]) begin
          $error("read_data: expected %0h actual %0h", read_queue[0], out_tdata);
          error_count++;
        end
        void'(read_queue.pop_front());
      end
    end
  end

  task automatic test_disabled;
    send_cmd(CMD_FILL, 8'd0, 8'd0, 8'hFF);
    send_cmd(CMD_READ, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_CHAR, 8'd0, 8'd0, "A");
  endtask

  task automatic test_directed;
    send_cmd(CMD_CHAR, 8'd0, 8'd0, "A");
    for (int i = 0; i < 6; i++) send_cmd(CMD_READ, 8'(i), 8'd0, 8'h00);
    send_cmd(CMD_CHAR, 8'd125, 8'd7, 8'd200);
    send_cmd(CMD_CHAR, 8'd10, 8'd1, 8'd127);
    send_cmd(CMD_CHAR, 8'd20, 8'd1, 8'd126);
    send_cmd(CMD_CHAR, 8'd255, 8'd255, "Z");
    send_cmd(CMD_DIGIT, 8'd120, 8'd6, "8");
    send_cmd(CMD_DIGIT, 8'd30, 8'd2, "0");
    send_cmd(CMD_DIGIT, 8'd30, 8'd2, "a");
    for (int i = 0; i < 3; i++) send_cmd(CMD_READ, 8'd30, 8'(2 + i), 8'h00);
    send_cmd(CMD_READ, 8'd127, 8'd7, 8'h00);
    send_cmd(CMD_READ, 8'd128, 8'd0, 8'h00);
    send_cmd(CMD_READ, 8'd0, 8'd8, 8'h00);
    send_cmd(CMD_FILL, 8'd3, 8'd3, 8'hA5);
    send_cmd(CMD_READ, 8'd77, 8'd3, 8'h00);
    send_cmd(3'd7, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(CMD_CLEAR, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_READ, 8'd30, 8'd3, 8'h00);
  endtask

  // Mostly small draws and reads; rare fills and clears keep the run short.
  task automatic send_random_item;
    int   r;
    logic [2:0] cmd;
    logic [7:0] col, page, sym;
    r = $urandom_range(99, 0);
    if (r < 30) cmd = CMD_CHAR;
    else if (r < 42) cmd = CMD_DIGIT;
    else if (r < 45) cmd = CMD_FILL;
    else if (r < 46) cmd = CMD_CLEAR;
    else if (r < 95) cmd = CMD_READ;
    else cmd = 3'($urandom_range(7, 5));
    col  = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'($urandom_range(Width - 1, 0));
    page = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'($urandom_range(Pages - 1, 0));
    if (cmd == CMD_DIGIT && $urandom_range(4, 0) != 0) sym = 8'($urandom_range("9", "0"));
    else if ($urandom_range(3, 0) != 0) sym = 8'($urandom_range(126, 32));
    else sym = 8'($urandom);
    send_cmd(cmd, col, page, sym);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) send_random_item();
  endtask

  // Hold the receiver off while reads keep coming so the input stalls.
  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      repeat (8) send_cmd(CMD_READ, 8'($urandom_range(Width - 1, 0)), 8'd0, 8'h00);
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    recv_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    model_enabled = 1'b0;
    for (int a = 0; a < Depth; a++) model_store[a] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled();
    set_enabled(1'b1);
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 61, 0);
    test_backpressure();
    test_random(250, 0, 61);
    set_enabled(1'b0);
    test_random(60, 0, 0);
    set_enabled(1'b1);
    test_random(250, 27, 27);
    in_tvalid <= 1'b0;
    while (read_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
